// ----- src/cal_pkg.sv -----
// shared types, constants and calendar helper functions for the date counter
`timescale 1ns / 1ps
package cal_pkg;

   typedef enum logic [1:0] {
      KIND_HOLD = 2'd0,
      KIND_NEXT = 2'd1,
      KIND_PREV = 2'd2,
      KIND_LOAD = 2'd3
   } kind_type;

   localparam logic [13:0] YEAR_MIN   = 14'd1;
   localparam logic [13:0] YEAR_MAX   = 14'd9999;
   localparam logic [13:0] YEAR_RESET = 14'd2000;
   localparam logic [3:0]  MONTH_MAX  = 4'd12;
   localparam logic [3:0]  MONTH_FEB  = 4'd2;
   localparam logic [3:0]  MONTH_MAR  = 4'd3;
   localparam logic [4:0]  DAY_DEC31  = 5'd31;
   localparam logic [6:0]  CENT_LAST  = 7'd99;
   localparam logic [2:0]  WEEKDAY_LAST = 3'd6;
   // 1 jan 2000: year 2000 is century 20, offset 0, a saturday
   localparam logic [6:0]  CENT_RESET = 7'd20;
   localparam logic [2:0]  WEEKDAY_RESET = 3'd0;
   // reciprocal of 25 scaled by 2^17, exact for dividends below 43690
   localparam logic [24:0] RECIP25    = 25'd5243;
   localparam int          RECIP25_SHIFT = 17;

   localparam logic [4:0] MONTH_LEN [13] =
      '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

   function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
      logic [4:0] n;
      n = 5'd0;
      if (month >= 4'd1 && month <= MONTH_MAX) begin
         n = MONTH_LEN[month];
         if (month == MONTH_FEB && leap) begin
            n = n + 5'd1;
         end
      end
      return n;
   endfunction

   // (13 * (m' + 1)) / 5 mod 7, with jan and feb counted as months 13 and 14
   function automatic logic [2:0] month_term(input logic [3:0] month);
      logic [2:0] t;
      case (month)
         4'd1:    t = 3'd1;
         4'd2:    t = 3'd4;
         4'd3:    t = 3'd3;
         4'd4:    t = 3'd6;
         4'd5:    t = 3'd1;
         4'd6:    t = 3'd4;
         4'd7:    t = 3'd6;
         4'd8:    t = 3'd2;
         4'd9:    t = 3'd5;
         4'd10:   t = 3'd0;
         4'd11:   t = 3'd3;
         4'd12:   t = 3'd5;
         default: t = 3'd0;
      endcase
      return t;
   endfunction

   // 8 = 1 mod 7, so octal digits fold together
   function automatic logic [2:0] mod7(input logic [9:0] x);
      logic [4:0] f1;
      logic [3:0] f2;
      f1 = 5'(x[9:6]) + 5'(x[5:3]) + 5'(x[2:0]);
      f2 = 4'(f1[4:3]) + 4'(f1[2:0]);
      if (f2 >= 4'd7) begin
         f2 = f2 - 4'd7;
      end
      return f2[2:0];
   endfunction

   // gregorian leap rule from year mod 4, year mod 100 and century mod 4
   function automatic logic leap_of(input logic [1:0] year_lo, input logic [6:0] offset,
                                    input logic [1:0] cent_lo);
      return (year_lo == 2'b00) && ((offset != 7'd0) || (cent_lo == 2'b00));
   endfunction

endpackage

// ----- src/calendar_date_counter.sv -----
// gregorian date counter with leap flag and zeller weekday
`timescale 1ns / 1ps
// Usage
// Each request item holds, advances one day, steps back one day or loads a
// date; each gives exactly one response item with the resulting date, the
// leap flag, the weekday (0 saturday .. 6 friday) and two status flags.
// Both channels use valid/ready; an item moves when valid and ready are high.
// Throughput is one item per cycle while the receiver takes responses: the
// date, century counters and weekday update together in the last stage, and
// the four stages before it only prepare the loaded date (divide by 100,
// validity, weekday) from the request alone.
// Each stage has its own valid bit and takes a new item when empty or
// moving on, so the pipe keeps filling while the response register is held
// by a stalled receiver; req_ready falls only once all five stages are full.
// Reset empties the pipe and sets the date to 1 jan 2000, a saturday.
module calendar_date_counter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cal_pkg::kind_type    req_kind,
   input  logic [4:0]           req_load_day,
   input  logic [3:0]           req_load_month,
   input  logic [13:0]          req_load_year,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [4:0]           rsp_cur_day,
   output logic [3:0]           rsp_cur_month,
   output logic [13:0]          rsp_cur_year,
   output logic                 rsp_is_leap,
   output logic [2:0]           rsp_weekday,
   output logic                 rsp_load_rejected,
   output logic                 rsp_year_saturated
);
   import cal_pkg::*;

   // stage valid bits and stage ready
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in, rsp_valid_in;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out, fire;

   // load path payload
   kind_type    s1_kind_ff, s2_kind_ff, s3_kind_ff, s4_kind_ff, s5_kind_ff;
   logic [4:0]  s1_day_ff, s2_day_ff, s3_day_ff, s4_day_ff, s5_day_ff;
   logic [3:0]  s1_month_ff, s2_month_ff, s3_month_ff, s4_month_ff, s5_month_ff;
   logic [13:0] s1_year_ff, s2_year_ff, s3_year_ff, s4_year_ff, s5_year_ff;
   logic [7:0]  s2_cent_ff, s3_cent_ff;
   logic [6:0]  s3_offs_ff;
   logic [6:0]  s4_offs_ff, s5_offs_ff, s4_cent_ff, s5_cent_ff;
   logic        s4_ok_ff, s5_ok_ff;
   logic [2:0]  s4_yterm_ff, s5_wday_ff;

   logic [24:0] prod;
   logic [7:0]  s2_cent_in;
   logic [13:0] rem_full;
   logic [6:0]  s3_offs_in;
   logic        leap_ld, ok_ld, early;
   logic [7:0]  cent_z;
   logic [6:0]  offs_z;
   logic [9:0]  yterm_sum;
   logic [9:0]  wday_sum;

   // date state
   logic [4:0]  day_ff, day_in;
   logic [3:0]  month_ff, month_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  offs_ff, offs_in;   // year mod 100
   logic [6:0]  cent_ff, cent_in;   // year / 100
   logic [2:0]  wday_ff, wday_in;
   logic        rej_ff, rej_in, sat_ff, sat_in;
   logic        leap_cur;
   logic [4:0]  dim_cur, dim_prev;

   // ready chain, each stage accepts when empty or draining
   assign rdy_out   = !rsp_valid_ff || rsp_ready;
   assign rdy5      = !v5_ff || rdy_out;
   assign rdy4      = !v4_ff || rdy5;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;
   assign fire      = v5_ff && rdy_out;

   always_comb begin
      v1_in        = rdy1 ? req_valid : v1_ff;
      v2_in        = rdy2 ? v1_ff : v2_ff;
      v3_in        = rdy3 ? v2_ff : v3_ff;
      v4_in        = rdy4 ? v3_ff : v4_ff;
      v5_in        = rdy5 ? v4_ff : v5_ff;
      rsp_valid_in = rdy_out ? v5_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         v5_ff        <= v5_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load path arithmetic
   always_comb begin
      // year / 100 = (year / 4) / 25 by reciprocal
      prod       = 25'(s1_year_ff[13:2]) * RECIP25;
      s2_cent_in = prod[24:RECIP25_SHIFT];

      rem_full   = s2_year_ff - (14'(s2_cent_ff) * 14'd100);
      s3_offs_in = rem_full[6:0];

      leap_ld = leap_of(s3_year_ff[1:0], s3_offs_ff, s3_cent_ff[1:0]);
      ok_ld   = (s3_year_ff >= YEAR_MIN) && (s3_year_ff <= YEAR_MAX) &&
                (s3_month_ff >= 4'd1) && (s3_month_ff <= MONTH_MAX) &&
                (s3_day_ff != 5'd0) &&
                (s3_day_ff <= days_in(s3_month_ff, leap_ld));

      // jan and feb count as months of the year before
      early  = s3_month_ff < MONTH_MAR;
      cent_z = s3_cent_ff;
      offs_z = s3_offs_ff;
      if (early) begin
         if (s3_offs_ff == 7'd0) begin
            cent_z = s3_cent_ff - 8'd1;
            offs_z = CENT_LAST;
         end else begin
            offs_z = s3_offs_ff - 7'd1;
         end
      end
      // y + y/4 - y/100 + y/400 with y = 100c + r is 124c + c/4 + r + r/4, 124 = 5 mod 7
      yterm_sum = 10'({cent_z, 2'b00}) + 10'(cent_z) + 10'(cent_z[7:2]) +
                  10'(offs_z) + 10'(offs_z[6:2]);

      wday_sum = 10'(s4_day_ff) + 10'(month_term(s4_month_ff)) + 10'(s4_yterm_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_kind_ff  <= req_kind;
         s1_day_ff   <= req_load_day;
         s1_month_ff <= req_load_month;
         s1_year_ff  <= req_load_year;
      end
      if (rdy2) begin
         s2_kind_ff  <= s1_kind_ff;
         s2_day_ff   <= s1_day_ff;
         s2_month_ff <= s1_month_ff;
         s2_year_ff  <= s1_year_ff;
         s2_cent_ff  <= s2_cent_in;
      end
      if (rdy3) begin
         s3_kind_ff  <= s2_kind_ff;
         s3_day_ff   <= s2_day_ff;
         s3_month_ff <= s2_month_ff;
         s3_year_ff  <= s2_year_ff;
         s3_cent_ff  <= s2_cent_ff;
         s3_offs_ff  <= s3_offs_in;
      end
      if (rdy4) begin
         s4_kind_ff  <= s3_kind_ff;
         s4_day_ff   <= s3_day_ff;
         s4_month_ff <= s3_month_ff;
         s4_year_ff  <= s3_year_ff;
         s4_cent_ff  <= s3_cent_ff[6:0];
         s4_offs_ff  <= s3_offs_ff;
         s4_ok_ff    <= ok_ld;
         s4_yterm_ff <= mod7(yterm_sum);
      end
      if (rdy5) begin
         s5_kind_ff  <= s4_kind_ff;
         s5_day_ff   <= s4_day_ff;
         s5_month_ff <= s4_month_ff;
         s5_year_ff  <= s4_year_ff;
         s5_cent_ff  <= s4_cent_ff;
         s5_offs_ff  <= s4_offs_ff;
         s5_ok_ff    <= s4_ok_ff;
         s5_wday_ff  <= mod7(wday_sum);
      end
   end

   // date state update
   assign leap_cur = leap_of(year_ff[1:0], offs_ff, cent_ff[1:0]);
   assign dim_cur  = days_in(month_ff, leap_cur);
   assign dim_prev = days_in(month_ff - 4'd1, leap_cur);

   always_comb begin
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      offs_in  = offs_ff;
      cent_in  = cent_ff;
      wday_in  = wday_ff;
      rej_in   = 1'b0;
      sat_in   = 1'b0;
      case (s5_kind_ff)
         KIND_HOLD: begin
         end
         KIND_NEXT: begin
            wday_in = (wday_ff == WEEKDAY_LAST) ? 3'd0 : wday_ff + 3'd1;
            if (day_ff < dim_cur) begin
               day_in = day_ff + 5'd1;
            end else if (month_ff < MONTH_MAX) begin
               month_in = month_ff + 4'd1;
               day_in   = 5'd1;
            end else if (year_ff < YEAR_MAX) begin
               year_in  = year_ff + 14'd1;
               month_in = 4'd1;
               day_in   = 5'd1;
               if (offs_ff == CENT_LAST) begin
                  offs_in = 7'd0;
                  cent_in = cent_ff + 7'd1;
               end else begin
                  offs_in = offs_ff + 7'd1;
               end
            end else begin
               sat_in  = 1'b1;
               wday_in = wday_ff;
            end
         end
         KIND_PREV: begin
            wday_in = (wday_ff == 3'd0) ? WEEKDAY_LAST : wday_ff - 3'd1;
            if (day_ff > 5'd1) begin
               day_in = day_ff - 5'd1;
            end else if (month_ff > 4'd1) begin
               month_in = month_ff - 4'd1;
               day_in   = dim_prev;
            end else if (year_ff > YEAR_MIN) begin
               year_in  = year_ff - 14'd1;
               month_in = MONTH_MAX;
               day_in   = DAY_DEC31;
               if (offs_ff == 7'd0) begin
                  offs_in = CENT_LAST;
                  cent_in = cent_ff - 7'd1;
               end else begin
                  offs_in = offs_ff - 7'd1;
               end
            end else begin
               sat_in  = 1'b1;
               wday_in = wday_ff;
            end
         end
         KIND_LOAD: begin
            if (s5_ok_ff) begin
               day_in   = s5_day_ff;
               month_in = s5_month_ff;
               year_in  = s5_year_ff;
               offs_in  = s5_offs_ff;
               cent_in  = s5_cent_ff;
               wday_in  = s5_wday_ff;
            end else begin
               rej_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff   <= 5'd1;
         month_ff <= 4'd1;
         year_ff  <= YEAR_RESET;
         offs_ff  <= 7'd0;
         cent_ff  <= CENT_RESET;
         wday_ff  <= WEEKDAY_RESET;
         rej_ff   <= 1'b0;
         sat_ff   <= 1'b0;
      end else if (fire) begin
         day_ff   <= day_in;
         month_ff <= month_in;
         year_ff  <= year_in;
         offs_ff  <= offs_in;
         cent_ff  <= cent_in;
         wday_ff  <= wday_in;
         rej_ff   <= rej_in;
         sat_ff   <= sat_in;
      end
   end

   // the state only moves when the response register loads, so it is the response
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cur_day        = day_ff;
   assign rsp_cur_month      = month_ff;
   assign rsp_cur_year       = year_ff;
   assign rsp_is_leap        = leap_cur;
   assign rsp_weekday        = wday_ff;
   assign rsp_load_rejected  = rej_ff;
   assign rsp_year_saturated = sat_ff;

   a_date_valid: assert property (@(posedge clock) disable iff (reset)
      (day_ff >= 5'd1) && (day_ff <= dim_cur) && (year_ff >= YEAR_MIN) &&
      (year_ff <= YEAR_MAX))
      else $error("stored date out of range");

   a_century_split: assert property (@(posedge clock) disable iff (reset)
      year_ff == (14'(cent_ff) * 14'd100) + 14'(offs_ff))
      else $error("century counters disagree with year");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      wday_ff <= WEEKDAY_LAST)
      else $error("weekday out of range");

   a_reject_keeps: assert property (@(posedge clock) disable iff (reset)
      fire && (s5_kind_ff == KIND_LOAD) && !s5_ok_ff |=>
         $stable(day_ff) && $stable(month_ff) && $stable(year_ff) && rej_ff)
      else $error("rejected load changed the date");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(rej_ff && sat_ff))
      else $error("reject and saturate flags both set");

endmodule
